FILE: rtl/sorted_key_value_table_core_assert.svh
// assertion macros for the sorted key-value table core
// used by the datapath module; no other dependencies
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SKVT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SKVT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/skvt_pkg.sv
// shared types and constants for the sorted key-value table core
// no dependencies; used by the controller, datapath and top level
package skvt_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port widths
    localparam int OP_W         = 3;
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_PORT_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
    localparam logic [OP_W-1:0] OP_UPSERT   = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_POS = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // write address select
    localparam logic [1:0] WA_DIDX    = 2'd0;
    localparam logic [1:0] WA_DIDX_M1 = 2'd1;
    localparam logic [1:0] WA_COUNT   = 2'd2;

    // write data select
    localparam logic [1:0] WD_NEW   = 2'd0;
    localparam logic [1:0] WD_CARRY = 2'd1;
    localparam logic [1:0] WD_READ  = 2'd2;

    // result source select
    localparam logic [1:0] RS_ECHO   = 2'd0;
    localparam logic [1:0] RS_LOOKUP = 2'd1;
    localparam logic [1:0] RS_ENTRY  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                scan;
        logic                rd_pos;
        logic                wr_en;
        logic [1:0]          wr_addr_sel;
        logic [1:0]          wr_data_sel;
        logic                carry_ld;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                res_ld;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_src;
        logic                out_ld;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            dv;
        logic            lt;
        logic            eq;
        logic            last;
        logic            exhausted;
        logic            full;
        logic            pos_ok;
        logic            out_free;
    } sts_t;

endpackage

FILE: rtl/skvt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module skvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/skvt_ctrl.sv
// controller state machine for the sorted key-value table core
// depends on skvt_pkg for command and status types and codes
module skvt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  skvt_pkg::sts_t sts,
    output skvt_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_INS_SH = 3'd3;
    localparam logic [2:0] S_ERA_SH = 3'd4;
    localparam logic [2:0] S_RDPOS  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        logic is_ins;
        logic hit;
        logic miss_here;
        logic miss_end;
        is_ins     = sts.op inside {skvt_pkg::OP_INSERT, skvt_pkg::OP_UPSERT};
        hit        = sts.dv && sts.eq;
        miss_here  = sts.dv && !sts.lt && !sts.eq;
        miss_end   = (sts.dv && sts.lt && sts.last) || (!sts.dv && sts.exhausted);
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                case (sts.op)
                    skvt_pkg::OP_READ_POS: begin
                        if (sts.pos_ok) begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RDPOS;
                        end else begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = skvt_pkg::ST_REFUSED;
                            cmd.res_src    = skvt_pkg::RS_ECHO;
                            state_next     = S_DONE;
                        end
                    end
                    skvt_pkg::OP_INSERT, skvt_pkg::OP_UPDATE, skvt_pkg::OP_UPSERT,
                    skvt_pkg::OP_ERASE, skvt_pkg::OP_LOOKUP: begin
                        state_next = S_SCAN;
                    end
                    default: begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = skvt_pkg::ST_REFUSED;
                        cmd.res_src    = skvt_pkg::RS_ECHO;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // ascending scan, reads stream one entry per cycle
                cmd.scan    = 1'b1;
                cmd.res_src = skvt_pkg::RS_ECHO;
                if (hit) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = skvt_pkg::ST_DONE;
                    state_next     = S_DONE;
                    case (sts.op)
                        skvt_pkg::OP_INSERT: begin
                            cmd.res_status = skvt_pkg::ST_REFUSED;
                        end
                        skvt_pkg::OP_UPDATE, skvt_pkg::OP_UPSERT: begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = skvt_pkg::WA_DIDX;
                            cmd.wr_data_sel = skvt_pkg::WD_NEW;
                        end
                        skvt_pkg::OP_ERASE: begin
                            if (sts.last) begin
                                cmd.cnt_dec = 1'b1;
                            end else begin
                                state_next = S_ERA_SH;
                            end
                        end
                        skvt_pkg::OP_LOOKUP: begin
                            cmd.res_src = skvt_pkg::RS_LOOKUP;
                        end
                        default: begin
                            cmd.res_status = skvt_pkg::ST_REFUSED;
                        end
                    endcase
                end else if (miss_here || miss_end) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = skvt_pkg::ST_REFUSED;
                    state_next     = S_DONE;
                    if (is_ins) begin
                        if (sts.full) begin
                            cmd.res_status = skvt_pkg::ST_FULL;
                        end else if (miss_here) begin
                            // place the new pair and start rippling upward
                            cmd.res_status  = skvt_pkg::ST_DONE;
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = skvt_pkg::WA_DIDX;
                            cmd.wr_data_sel = skvt_pkg::WD_NEW;
                            cmd.carry_ld    = 1'b1;
                            state_next      = S_INS_SH;
                        end else begin
                            // append after the last entry
                            cmd.res_status  = skvt_pkg::ST_DONE;
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr_sel = skvt_pkg::WA_COUNT;
                            cmd.wr_data_sel = skvt_pkg::WD_NEW;
                            cmd.cnt_inc     = 1'b1;
                        end
                    end
                end
            end
            S_INS_SH: begin
                // write carried entry one slot up, take the next one
                cmd.scan        = 1'b1;
                cmd.wr_en       = 1'b1;
                cmd.wr_data_sel = skvt_pkg::WD_CARRY;
                if (sts.dv) begin
                    cmd.wr_addr_sel = skvt_pkg::WA_DIDX;
                    cmd.carry_ld    = 1'b1;
                end else begin
                    cmd.wr_addr_sel = skvt_pkg::WA_COUNT;
                    cmd.cnt_inc     = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_ERA_SH: begin
                // move each later entry one slot down
                cmd.scan = 1'b1;
                if (sts.dv) begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_addr_sel = skvt_pkg::WA_DIDX_M1;
                    cmd.wr_data_sel = skvt_pkg::WD_READ;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_RDPOS: begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = skvt_pkg::ST_DONE;
                cmd.res_src    = skvt_pkg::RS_ENTRY;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/skvt_datapath.sv
// datapath of the sorted key-value table core: key and value memories,
// request, scan, carry and result registers; depends on skvt_pkg, skvt_ram
`include "sorted_key_value_table_core_assert.svh"

module skvt_datapath #(
    parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  skvt_pkg::cmd_t                          cmd,
    output skvt_pkg::sts_t                          sts,
    input  logic [skvt_pkg::OP_W-1:0]               s_op,
    input  logic [skvt_pkg::KEY_PORT_W-1:0]         s_key,
    input  logic signed [skvt_pkg::VALUE_PORT_W-1:0] s_value,
    input  logic [skvt_pkg::POS_W-1:0]              s_position,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [skvt_pkg::STATUS_W-1:0]           m_status,
    output logic [skvt_pkg::KEY_PORT_W-1:0]         m_found_key,
    output logic signed [skvt_pkg::VALUE_PORT_W-1:0] m_found_value,
    output logic [skvt_pkg::COUNT_PORT_W-1:0]       m_entry_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int KW  = (KEY_BITS < skvt_pkg::KEY_PORT_W) ? KEY_BITS : skvt_pkg::KEY_PORT_W;
    localparam int VW  = (VALUE_BITS < skvt_pkg::VALUE_PORT_W) ?
                         VALUE_BITS : skvt_pkg::VALUE_PORT_W;
    localparam int PCW = (CW > skvt_pkg::POS_W) ? CW : skvt_pkg::POS_W;
    localparam int OCW = (CW > skvt_pkg::COUNT_PORT_W) ? CW : skvt_pkg::COUNT_PORT_W;

    // request registers
    logic [skvt_pkg::OP_W-1:0]  op_reg;
    logic [KW-1:0]              key_reg;
    logic [VW-1:0]              val_reg;
    logic [skvt_pkg::POS_W-1:0] pos_reg;

    // table and scan state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] iss_reg;
    logic          dv_reg;
    logic [CW-1:0] didx_reg;
    logic [KW-1:0] carry_key_reg;
    logic [VW-1:0] carry_val_reg;

    // pending result and output registers
    logic [skvt_pkg::STATUS_W-1:0]     res_status_reg;
    logic [KW-1:0]                     res_key_reg;
    logic [VW-1:0]                     res_val_reg;
    logic                              m_valid_reg;
    logic [skvt_pkg::STATUS_W-1:0]     m_status_reg;
    logic [skvt_pkg::KEY_PORT_W-1:0]   m_found_key_reg;
    logic [skvt_pkg::VALUE_PORT_W-1:0] m_found_value_reg;
    logic [skvt_pkg::COUNT_PORT_W-1:0] m_entry_count_reg;

    // memory ports
    logic          issue;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] wr_addr_w;
    logic [KW-1:0] wr_key;
    logic [VW-1:0] wr_val;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [PCW-1:0] pos_ext;
    logic [PCW-1:0] cnt_pext;
    logic [OCW-1:0] cnt_oext;

    skvt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr_w[AW-1:0]),
        .wr_data (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    skvt_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr_w[AW-1:0]),
        .wr_data (wr_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_val)
    );

    // read side: sequential scan or a single positional read
    assign issue    = cmd.scan && (iss_reg < count_reg);
    assign pos_ext  = PCW'(pos_reg);
    assign cnt_pext = PCW'(count_reg);
    assign rd_en    = issue || cmd.rd_pos;
    assign rd_addr  = cmd.rd_pos ? pos_ext[AW-1:0] : iss_reg[AW-1:0];

    // write side address and data
    always_comb begin
        case (cmd.wr_addr_sel)
            skvt_pkg::WA_DIDX:    wr_addr_w = didx_reg;
            skvt_pkg::WA_DIDX_M1: wr_addr_w = didx_reg - CW'(1);
            skvt_pkg::WA_COUNT:   wr_addr_w = count_reg;
            default:              wr_addr_w = didx_reg;
        endcase
        case (cmd.wr_data_sel)
            skvt_pkg::WD_NEW: begin
                wr_key = key_reg;
                wr_val = val_reg;
            end
            skvt_pkg::WD_CARRY: begin
                wr_key = carry_key_reg;
                wr_val = carry_val_reg;
            end
            skvt_pkg::WD_READ: begin
                wr_key = rd_key;
                wr_val = rd_val;
            end
            default: begin
                wr_key = key_reg;
                wr_val = val_reg;
            end
        endcase
    end

    // status to controller
    assign sts.op        = op_reg;
    assign sts.dv        = dv_reg;
    assign sts.lt        = rd_key < key_reg;
    assign sts.eq        = rd_key == key_reg;
    assign sts.last      = (didx_reg + CW'(1)) == count_reg;
    assign sts.exhausted = iss_reg >= count_reg;
    assign sts.full      = count_reg == CW'(CAPACITY);
    assign sts.pos_ok    = pos_ext < cnt_pext;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // request capture and scan pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg <= '0;
            dv_reg  <= 1'b0;
        end else if (cmd.load) begin
            iss_reg <= '0;
            dv_reg  <= 1'b0;
        end else begin
            if (issue) begin
                iss_reg <= iss_reg + CW'(1);
            end
            dv_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_op;
            key_reg <= s_key[KW-1:0];
            val_reg <= s_value[VW-1:0];
            pos_reg <= s_position;
        end
        if (issue) begin
            didx_reg <= iss_reg;
        end
        if (cmd.carry_ld) begin
            carry_key_reg <= rd_key;
            carry_val_reg <= rd_val;
        end
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (cmd.res_ld) begin
            res_status_reg <= cmd.res_status;
            res_key_reg    <= (cmd.res_src == skvt_pkg::RS_ENTRY) ? rd_key : key_reg;
            res_val_reg    <= (cmd.res_src == skvt_pkg::RS_ECHO) ? '0 : rd_val;
        end
    end

    // output register
    assign cnt_oext = OCW'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_status_reg      <= res_status_reg;
            m_found_key_reg   <= skvt_pkg::KEY_PORT_W'(res_key_reg);
            m_found_value_reg <= skvt_pkg::VALUE_PORT_W'(signed'(res_val_reg));
            m_entry_count_reg <= cnt_oext[skvt_pkg::COUNT_PORT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_key   = m_found_key_reg;
    assign m_found_value = m_found_value_reg;
    assign m_entry_count = m_entry_count_reg;

    // checks
    `SKVT_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_ld, !m_valid_reg || m_ready, "result register overwritten before taken")
    `SKVT_ASSERT_SAME(a_grow_room, aclk, aresetn, cmd.cnt_inc, count_reg < CW'(CAPACITY), "insert into a full table")
    `SKVT_ASSERT_SAME(a_shrink_nonempty, aclk, aresetn, cmd.cnt_dec, count_reg != '0, "erase from an empty table")
    `SKVT_ASSERT_SAME(a_write_in_range, aclk, aresetn, cmd.wr_en, wr_addr_w < CW'(CAPACITY), "write beyond capacity")
    `SKVT_ASSERT_NEXT(a_scan_stream, aclk, aresetn, dv_reg && cmd.scan && !cmd.load && !sts.last, dv_reg, "scan stream broke before the last entry")

endmodule

FILE: rtl/sorted_key_value_table_core.sv
// Sorted key-value table: keeps up to CAPACITY pairs in ascending order of
// unique unsigned keys and answers one request at a time (insert, update,
// insert-or-update, erase, lookup, read by sorted position) with a status,
// key, value and entry count. Keys and values live in two single-port-read
// memories, so a request scans entries in ascending order, one per cycle,
// up to the match or insertion point; an insert or erase that shifts
// entries carries its shift along with the scan through the last entry.
// A read by position, a refused read by position and an unused op do not scan.
// A finished result waits in an output register while the next item is
// accepted; a result that finds that register still full holds the request
// until the waiting item is taken.
// Depends on skvt_pkg, skvt_ctrl, skvt_datapath and skvt_ram.
module sorted_key_value_table_core #(
    parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [skvt_pkg::OP_W-1:0]                s_op,
    input  logic [skvt_pkg::KEY_PORT_W-1:0]          s_key,
    input  logic signed [skvt_pkg::VALUE_PORT_W-1:0] s_value,
    input  logic [skvt_pkg::POS_W-1:0]               s_position,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [skvt_pkg::STATUS_W-1:0]            m_status,
    output logic [skvt_pkg::KEY_PORT_W-1:0]          m_found_key,
    output logic signed [skvt_pkg::VALUE_PORT_W-1:0] m_found_value,
    output logic [skvt_pkg::COUNT_PORT_W-1:0]        m_entry_count
);

    skvt_pkg::cmd_t cmd;
    skvt_pkg::sts_t sts;

    // sequencing
    skvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage and result path
    skvt_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_op          (s_op),
        .s_key         (s_key),
        .s_value       (s_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_key   (m_found_key),
        .m_found_value (m_found_value),
        .m_entry_count (m_entry_count)
    );

endmodule
